// ----- src/nfba_pkg.sv -----
// Shared types and constants for the next-fit block allocator.
`default_nettype none

package nfba_pkg;

  localparam int CFG_W = 11;
  localparam int BLK_W = 10;
  localparam int OWN_W = 10;
  localparam int DEF_MAX_BLOCKS = 1024;
  localparam int TOTAL_RESET = 1024;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_WRITE   = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t             command;
    logic [OWN_W-1:0] owner;
    logic             owner_is_self;
    logic [BLK_W-1:0] block_index;
    logic             entry_free;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] result_block;
    logic [OWN_W-1:0] result_owner;
    logic             result_free;
  } out_word_t;

  typedef struct packed {
    logic             free;
    logic [OWN_W-1:0] owner;
  } entry_t;

  localparam entry_t ENTRY_FREE = '{free: 1'b1, owner: '0};

endpackage

`default_nettype wire

// ----- src/next_fit_block_allocator.sv -----
// Next-fit block allocation map: owner table memory, search pointer and command sequencer.
//
// Channel  Ports                          Transfer
// input    start, busy, in_word           at clk edge with start && !busy
// result   out_strobe, out_word           one-cycle strobe, no back-pressure
// config   cfg_valid, cfg_ready, cfg_word at clk edge with cfg_valid && cfg_ready
//
// Release, write and out-of-range commands: result in the cycle after acceptance; read:
// table read register, then result register. Allocate: entries are read from the search
// pointer, wrapping at the block count, until a free one or none (full) is found; first a
// remainder step if the pointer lies beyond a lowered count. One table read a cycle.
// After reset a pass clears all MAX_BLOCKS entries with busy high; config still taken.
// Results cannot be stalled; busy holds off the next word while one is in progress.
`default_nettype none

module next_fit_block_allocator #(
  parameter int MAX_BLOCKS = nfba_pkg::DEF_MAX_BLOCKS
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire nfba_pkg::in_word_t         in_word,
  output logic                            out_strobe,
  output nfba_pkg::out_word_t             out_word,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [nfba_pkg::CFG_W-1:0]       cfg_word
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int PTR_W  = nfba_pkg::CFG_W;
  localparam int MODC_W = $clog2(PTR_W);
  localparam int SAT    = (MAX_BLOCKS < 2**PTR_W) ? MAX_BLOCKS : 2**PTR_W - 1;
  localparam int RSTV   = (nfba_pkg::TOTAL_RESET > SAT) ? SAT : nfba_pkg::TOTAL_RESET;
  localparam logic [PTR_W-1:0]  TOT_MAX  = PTR_W'(SAT);
  localparam logic [PTR_W-1:0]  TOT_RST  = PTR_W'(RSTV);
  localparam logic [IDX_W-1:0]  ADDR_END = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [IDX_W-1:0]  ADDR_ONE = IDX_W'(1);
  localparam logic [PTR_W-1:0]  PTR_ONE  = PTR_W'(1);
  localparam logic [MODC_W-1:0] MODC_END = MODC_W'(PTR_W - 1);
  localparam logic [MODC_W-1:0] MODC_ONE = MODC_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_READ
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          out_strobe_r, out_strobe_nxt;
  nfba_pkg::out_word_t           out_word_r, out_word_nxt;
  logic [PTR_W-1:0]              total_r, total_nxt;
  logic [PTR_W-1:0]              ptr_r, ptr_nxt;
  logic [IDX_W-1:0]              clr_addr_r, clr_addr_nxt;
  logic [PTR_W-1:0]              iss_pos_r, iss_pos_nxt;
  logic [PTR_W-1:0]              chk_pos_r, chk_pos_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [PTR_W-1:0]              chk_cnt_r, chk_cnt_nxt;
  logic [PTR_W-1:0]              mod_rem_r, mod_rem_nxt;
  logic [PTR_W-1:0]              mod_sh_r, mod_sh_nxt;
  logic [MODC_W-1:0]             mod_cnt_r, mod_cnt_nxt;
  logic [nfba_pkg::OWN_W-1:0]    own_r, own_nxt;
  logic                          self_r, self_nxt;
  logic [nfba_pkg::BLK_W-1:0]    blk_r, blk_nxt;

  logic [PTR_W:0]                mod_t;
  logic [PTR_W-1:0]              mod_new;
  logic [PTR_W-1:0]              chk_cnt_inc;

  nfba_pkg::entry_t              tbl_mem [MAX_BLOCKS];
  nfba_pkg::entry_t              rd_data_r;
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_wa;
  nfba_pkg::entry_t              mem_wd;
  logic                          mem_re;
  logic [IDX_W-1:0]              mem_ra;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] pos,
                                                input logic [PTR_W-1:0] tot);
    logic [PTR_W-1:0] inc;
    inc = pos + PTR_ONE;
    return (inc == tot) ? '0 : inc;
  endfunction

  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  assign mod_t       = {mod_rem_r, mod_sh_r[PTR_W-1]};
  assign mod_new     = (mod_t >= {1'b0, total_r}) ? PTR_W'(mod_t - {1'b0, total_r})
                                                  : mod_t[PTR_W-1:0];
  assign chk_cnt_inc = chk_cnt_r + PTR_ONE;

  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    total_nxt      = total_r;
    ptr_nxt        = ptr_r;
    clr_addr_nxt   = clr_addr_r;
    iss_pos_nxt    = iss_pos_r;
    chk_pos_nxt    = chk_pos_r;
    chk_vld_nxt    = chk_vld_r;
    chk_cnt_nxt    = chk_cnt_r;
    mod_rem_nxt    = mod_rem_r;
    mod_sh_nxt     = mod_sh_r;
    mod_cnt_nxt    = mod_cnt_r;
    own_nxt        = own_r;
    self_nxt       = self_r;
    blk_nxt        = blk_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = nfba_pkg::ENTRY_FREE;
    mem_re         = 1'b0;
    mem_ra         = '0;

    if (cfg_valid) begin
      total_nxt = (cfg_word > TOT_MAX) ? TOT_MAX : cfg_word;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_addr_r;
        clr_addr_nxt = clr_addr_r + ADDR_ONE;
        if (clr_addr_r == ADDR_END) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          own_nxt  = in_word.owner;
          self_nxt = in_word.owner_is_self;
          blk_nxt  = in_word.block_index;
          out_word_nxt.result_block = in_word.block_index;
          out_word_nxt.result_owner = '0;
          out_word_nxt.result_free  = 1'b0;
          out_word_nxt.status       = nfba_pkg::ST_OK;
          if (in_word.command == nfba_pkg::CMD_ALLOC) begin
            chk_vld_nxt = 1'b0;
            chk_cnt_nxt = '0;
            if (total_r == '0) begin
              out_word_nxt.status       = nfba_pkg::ST_FULL;
              out_word_nxt.result_block = '0;
              out_strobe_nxt            = 1'b1;
            end else if (ptr_r >= total_r) begin
              mod_rem_nxt = '0;
              mod_sh_nxt  = ptr_r;
              mod_cnt_nxt = '0;
              state_nxt   = S_MOD;
            end else begin
              iss_pos_nxt = ptr_r;
              state_nxt   = S_SCAN;
            end
          end else if ({1'b0, in_word.block_index} >= total_r) begin
            out_word_nxt.status = nfba_pkg::ST_RANGE;
            out_strobe_nxt      = 1'b1;
          end else begin
            unique case (in_word.command)
              nfba_pkg::CMD_RELEASE: begin
                mem_we         = 1'b1;
                mem_wa         = IDX_W'(in_word.block_index);
                out_strobe_nxt = 1'b1;
              end
              nfba_pkg::CMD_WRITE: begin
                mem_we         = 1'b1;
                mem_wa         = IDX_W'(in_word.block_index);
                mem_wd.free    = in_word.entry_free;
                mem_wd.owner   = in_word.entry_free ? '0 : in_word.owner;
                out_strobe_nxt = 1'b1;
              end
              nfba_pkg::CMD_READ: begin
                mem_re    = 1'b1;
                mem_ra    = IDX_W'(in_word.block_index);
                state_nxt = S_READ;
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_MOD: begin
        mod_rem_nxt = mod_new;
        mod_sh_nxt  = mod_sh_r << 1;
        mod_cnt_nxt = mod_cnt_r + MODC_ONE;
        if (mod_cnt_r == MODC_END) begin
          iss_pos_nxt = mod_new;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        mem_re      = 1'b1;
        mem_ra      = IDX_W'(iss_pos_r);
        iss_pos_nxt = wrap_inc(iss_pos_r, total_r);
        chk_pos_nxt = iss_pos_r;
        chk_vld_nxt = 1'b1;
        if (chk_vld_r) begin
          if (rd_data_r.free) begin
            mem_we       = 1'b1;
            mem_wa       = IDX_W'(chk_pos_r);
            mem_wd.free  = 1'b0;
            mem_wd.owner = self_r ? chk_pos_r[nfba_pkg::OWN_W-1:0] : own_r;
            ptr_nxt      = wrap_inc(chk_pos_r, total_r);
            out_word_nxt.status       = nfba_pkg::ST_OK;
            out_word_nxt.result_block = chk_pos_r[nfba_pkg::BLK_W-1:0];
            out_strobe_nxt = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            chk_cnt_nxt = chk_cnt_inc;
            if (chk_cnt_inc == total_r) begin
              out_word_nxt.status       = nfba_pkg::ST_FULL;
              out_word_nxt.result_block = '0;
              out_strobe_nxt = 1'b1;
              state_nxt      = S_IDLE;
            end
          end
        end
      end
      S_READ: begin
        out_word_nxt.status       = nfba_pkg::ST_OK;
        out_word_nxt.result_block = blk_r;
        out_word_nxt.result_free  = rd_data_r.free;
        out_word_nxt.result_owner = rd_data_r.free ? '0 : rd_data_r.owner;
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_strobe_r <= 1'b0;
      total_r      <= TOT_RST;
      ptr_r        <= '0;
      clr_addr_r   <= '0;
      chk_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      total_r      <= total_nxt;
      ptr_r        <= ptr_nxt;
      clr_addr_r   <= clr_addr_nxt;
      chk_vld_r    <= chk_vld_nxt;
    end
    out_word_r <= out_word_nxt;
    iss_pos_r  <= iss_pos_nxt;
    chk_pos_r  <= chk_pos_nxt;
    chk_cnt_r  <= chk_cnt_nxt;
    mod_rem_r  <= mod_rem_nxt;
    mod_sh_r   <= mod_sh_nxt;
    mod_cnt_r  <= mod_cnt_nxt;
    own_r      <= own_nxt;
    self_r     <= self_nxt;
    blk_r      <= blk_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= tbl_mem[mem_ra];
    end
  end

`ifndef SYNTHESIS
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_SCAN || $past(state_r) == S_READ
                    || $past(start && !busy)))
    else $error("result word without a command in progress");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !out_strobe && busy)
    else $error("result or idle during clearing pass");

  a_found_gives_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && chk_vld_r && rd_data_r.free)
      |=> out_strobe && out_word.status == nfba_pkg::ST_OK)
    else $error("free entry found but no ok result");

  a_scan_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_SCAN && state_r == S_IDLE) |-> out_strobe)
    else $error("allocate finished without a result word");
`endif

endmodule

`default_nettype wire
